[rtl/gifd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifd_pkg
// Shared types and constants of the GIF LZW pixel decoder.
// ----------------------------------------------------------------------------
package gifd_pkg;

  localparam int DICT_SIZE       = 4096;
  localparam int MAX_CODE_BITS   = 12;
  localparam int BIT_BUFFER_BITS = 32;
  localparam int CODE_W          = 12;  // dictionary address width
  localparam int DEPTH_W         = 13;  // stack depth counter
  localparam int NF_W            = 13;  // next free code
  localparam int BCNT_W          = 6;   // bit buffer fill
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLACED = 2'd3;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // result status codes
  localparam logic [2:0] ST_PIXEL   = 3'd0;
  localparam logic [2:0] ST_ACCEPT  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NEED    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_BADCODE = 3'd5;
  localparam logic [2:0] ST_OUTSIDE = 3'd6;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_pull;
    logic       len_zero;  // byte is zero
    logic [7:0] data_byte;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/gifd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifd_front
// Accepts input requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module gifd_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  gifd_pkg::in_t     in_data_i,
  output logic              cmd_valid_o,
  output gifd_pkg::cmd_t    cmd_o,
  input  wire               cmd_pop_i
);
  import gifd_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.is_pull   = (in_data_i.opcode == OP_PULL);
    cls.len_zero  = (in_data_i.data_byte == 8'd0);
    cls.data_byte = in_data_i.data_byte;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = cmd_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/gifd_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifd_engine
// Executes queued requests: bit packing, LZW code expansion, pixel placement.
// ----------------------------------------------------------------------------
module gifd_engine (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [gifd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [gifd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire                                 cmd_valid_i,
  input  gifd_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output gifd_pkg::out_t                      out_data_o
);
  import gifd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_WDATA  = 4'd3;
  localparam logic [3:0] S_FINAL  = 4'd4;
  localparam logic [3:0] S_POPRD  = 4'd5;
  localparam logic [3:0] S_POPOUT = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  typedef struct packed {
    logic [15:0] col;
    logic [16:0] row;
    logic [2:0]  pass;
  } pos_t;

  // configuration
  logic [3:0]  root_q;
  logic [15:0] width_q, height_q;
  logic        ilace_q;

  // decoder state
  logic [3:0]                 st_q, st_d;
  logic [DEPTH_W-1:0]         depth_q, depth_d;
  logic [BIT_BUFFER_BITS-1:0] buf_q, buf_d;
  logic [BCNT_W-1:0]          bcnt_q, bcnt_d;
  logic [7:0]                 bbl_q, bbl_d;
  logic                       eod_q, eod_d;
  logic [3:0]                 cw_q, cw_d;
  logic [NF_W-1:0]            nf_q, nf_d;
  logic [CODE_W-1:0]          prev_q, prev_d;
  logic                       pv_q, pv_d;
  logic [7:0]                 fc_q, fc_d;
  pos_t                       pos_q, pos_d;
  logic                       fin_q, fin_d;
  logic [CODE_W-1:0]          code_q, code_d;
  logic [CODE_W-1:0]          c_q, c_d;
  out_t                       res_q, res_d;
  logic                       ov_q, ov_d;
  out_t                       od_q, od_d;

  // memories
  logic [CODE_W-1:0] pre_mem [DICT_SIZE];
  logic [7:0]        suf_mem [DICT_SIZE];
  logic [7:0]        stk_mem [DICT_SIZE];
  logic [CODE_W-1:0] pre_rd_q;
  logic [7:0]        suf_rd_q, stk_rd_q;
  logic              dict_we, stk_we;
  logic [CODE_W-1:0] dict_wa, stk_wa, stk_ra;
  logic [CODE_W-1:0] dict_wpre;
  logic [7:0]        dict_wsuf, stk_wd;

  logic [3:0]        er;
  logic [NF_W-1:0]   clr, eoi;
  logic [CODE_W-1:0] code_w;
  logic [NF_W-1:0]   nf_inc;
  logic              out_free;

  function automatic logic [3:0] eff_root(input logic [3:0] r);
    if (r < 4'd2) return 4'd2;
    if (r > 4'd8) return 4'd8;
    return r;
  endfunction

  // Step the raster position; skip interlace passes that start past the frame.
  function automatic pos_t advance(input pos_t p, input logic [15:0] w,
                                   input logic [15:0] h, input logic il);
    pos_t        n;
    logic [16:0] c1;
    n  = p;
    c1 = {1'b0, p.col} + 17'd1;
    if (c1 < {1'b0, w}) begin
      n.col = c1[15:0];
    end else begin
      n.col = 16'd0;
      if (!il) begin
        n.row = p.row + 17'd1;
      end else begin
        if (p.pass <= 3'd2)      n.row = p.row + 17'd8;
        else if (p.pass == 3'd3) n.row = p.row + 17'd4;
        else                     n.row = p.row + 17'd2;
        for (int i = 0; i < 4; i++) begin
          if (n.row >= {1'b0, h} && n.pass < 3'd5) begin
            n.pass = n.pass + 3'd1;
            if (n.pass == 3'd2)      n.row = 17'd4;
            else if (n.pass == 3'd3) n.row = 17'd2;
            else if (n.pass == 3'd4) n.row = 17'd1;
          end
        end
      end
    end
    return n;
  endfunction

  assign er       = eff_root(root_q);
  assign clr      = NF_W'(1) << er;
  assign eoi      = clr + NF_W'(1);
  assign code_w   = CODE_W'(buf_q & ((BIT_BUFFER_BITS'(1) << cw_q) - BIT_BUFFER_BITS'(1)));
  assign nf_inc   = nf_q + NF_W'(1);
  assign out_free = !ov_q || !out_stall_i;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_comb begin
    st_d = st_q;  depth_d = depth_q; buf_d = buf_q; bcnt_d = bcnt_q;
    bbl_d = bbl_q; eod_d = eod_q; cw_d = cw_q; nf_d = nf_q; prev_d = prev_q;
    pv_d = pv_q; fc_d = fc_q; pos_d = pos_q; fin_d = fin_q; code_d = code_q;
    c_d = c_q; res_d = res_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    cmd_pop_o = 1'b0;
    dict_we = 1'b0; dict_wa = nf_q[CODE_W-1:0]; dict_wpre = prev_q; dict_wsuf = c_q[7:0];
    stk_we = 1'b0; stk_wa = depth_q[CODE_W-1:0]; stk_wd = fc_q;
    stk_ra = CODE_W'(depth_q - DEPTH_W'(1));

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          res_d     = '0;
          st_d      = S_EMIT;
          if (!cmd_i.is_pull) begin
            res_d.status = ST_ACCEPT;
            if (eod_q) begin
              res_d.status = ST_DONE;
            end else if (bbl_q == 8'd0) begin
              if (cmd_i.len_zero) eod_d = 1'b1;
              else                bbl_d = cmd_i.data_byte;
            end else if (bcnt_q > BCNT_W'(BIT_BUFFER_BITS - 8)) begin
              res_d.status = ST_FULL;
            end else begin
              buf_d  = buf_q | (BIT_BUFFER_BITS'(cmd_i.data_byte) << bcnt_q);
              bcnt_d = bcnt_q + BCNT_W'(8);
              bbl_d  = bbl_q - 8'd1;
            end
          end else if (depth_q != '0) begin
            st_d = S_POPRD;
          end else if (fin_q) begin
            res_d.status = ST_DONE;
          end else begin
            st_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        res_d = '0;
        if (bcnt_q < BCNT_W'(cw_q)) begin
          if (eod_q) begin
            fin_d = 1'b1;
            res_d.status = ST_DONE;
          end else begin
            res_d.status = ST_NEED;
          end
          st_d = S_EMIT;
        end else begin
          buf_d  = buf_q >> cw_q;
          bcnt_d = bcnt_q - BCNT_W'(cw_q);
          if (NF_W'(code_w) == clr) begin
            cw_d = er + 4'd1;
            nf_d = clr + NF_W'(2);
            pv_d = 1'b0;
            prev_d = '0;
          end else if (NF_W'(code_w) == eoi) begin
            fin_d = 1'b1;
            res_d.status = ST_DONE;
            st_d = S_EMIT;
          end else if ((NF_W'(code_w) >= NF_W'(DICT_SIZE)) || (NF_W'(code_w) > nf_q) ||
                       ((NF_W'(code_w) == nf_q) && !pv_q)) begin
            fin_d = 1'b1;
            res_d.status = ST_BADCODE;
            st_d = S_EMIT;
          end else begin
            code_d = code_w;
            st_d   = S_WALK;
            if (NF_W'(code_w) == nf_q) begin
              // KwKwK: the string ends in its own first character
              stk_we  = 1'b1;
              stk_wa  = '0;
              stk_wd  = fc_q;
              depth_d = DEPTH_W'(1);
              c_d     = prev_q;
            end else begin
              depth_d = '0;
              c_d     = code_w;
            end
          end
        end
      end
      S_WALK: begin
        if ((NF_W'(c_q) >= clr + NF_W'(2)) && (depth_q < DEPTH_W'(DICT_SIZE - 1))) begin
          st_d = S_WDATA;
        end else begin
          st_d = S_FINAL;
        end
      end
      S_WDATA: begin
        stk_we  = 1'b1;
        stk_wd  = suf_rd_q;
        depth_d = depth_q + DEPTH_W'(1);
        c_d     = pre_rd_q;
        st_d    = S_WALK;
      end
      S_FINAL: begin
        stk_we  = 1'b1;
        stk_wd  = c_q[7:0];
        depth_d = depth_q + DEPTH_W'(1);
        fc_d    = c_q[7:0];
        if (pv_q && (nf_q < NF_W'(DICT_SIZE))) begin
          dict_we = 1'b1;
          nf_d    = nf_inc;
          if ((nf_inc >= (NF_W'(1) << cw_q)) && (cw_q < 4'(MAX_CODE_BITS))) begin
            cw_d = cw_q + 4'd1;
          end
        end
        prev_d = code_q;
        pv_d   = 1'b1;
        st_d   = S_POPRD;
      end
      S_POPRD: begin
        st_d = S_POPOUT;
      end
      S_POPOUT: begin
        depth_d = depth_q - DEPTH_W'(1);
        res_d   = '0;
        if (pos_q.row >= {1'b0, height_q}) begin
          res_d.status = ST_OUTSIDE;
        end else begin
          res_d.status      = ST_PIXEL;
          res_d.pixel_index = stk_rd_q;
          res_d.pixel_x     = pos_q.col;
          res_d.pixel_y     = pos_q.row[15:0];
          pos_d = advance(pos_q, width_q, height_q, ilace_q);
        end
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d = res_q;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    // any configuration write restarts the decoder
    if (cfg_we_i) begin
      st_d = S_IDLE; depth_d = '0; buf_d = '0; bcnt_d = '0; bbl_d = '0; eod_d = 1'b0;
      fc_d = '0; pos_d = '{col: '0, row: '0, pass: 3'd1}; fin_d = 1'b0;
      pv_d = 1'b0; prev_d = '0;
      cw_d = 4'd9; nf_d = NF_W'(258);
      unique case (cfg_idx_i)
        CFG_ROOT_BITS: begin
          cw_d = eff_root(cfg_data_i[3:0]) + 4'd1;
          nf_d = (NF_W'(1) << eff_root(cfg_data_i[3:0])) + NF_W'(2);
        end
        default: begin
          cw_d = er + 4'd1;
          nf_d = clr + NF_W'(2);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= 4'd8; width_q <= 16'd1; height_q <= 16'd1; ilace_q <= 1'b0;
      st_q <= S_IDLE; depth_q <= '0; buf_q <= '0; bcnt_q <= '0; bbl_q <= '0;
      eod_q <= 1'b0; cw_q <= 4'd9; nf_q <= NF_W'(258); prev_q <= '0; pv_q <= 1'b0;
      fc_q <= '0; pos_q <= '{col: '0, row: '0, pass: 3'd1}; fin_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROOT_BITS:  root_q   <= cfg_data_i[3:0];
          CFG_WIDTH:      width_q  <= cfg_data_i;
          CFG_HEIGHT:     height_q <= cfg_data_i;
          CFG_INTERLACED: ilace_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      st_q <= st_d; depth_q <= depth_d; buf_q <= buf_d; bcnt_q <= bcnt_d;
      bbl_q <= bbl_d; eod_q <= eod_d; cw_q <= cw_d; nf_q <= nf_d; prev_q <= prev_d;
      pv_q <= pv_d; fc_q <= fc_d; pos_q <= pos_d; fin_q <= fin_d; ov_q <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    c_q    <= c_d;
    res_q  <= res_d;
    od_q   <= od_d;
  end

  // dictionary: written once per new code, read once per chain step
  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      pre_mem[dict_wa] <= dict_wpre;
      suf_mem[dict_wa] <= dict_wsuf;
    end
    pre_rd_q <= pre_mem[c_q];
    suf_rd_q <= suf_mem[c_q];
  end

  // expansion stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

endmodule
`default_nettype wire

[rtl/gif_lzw_pixel_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder
// GIF raster LZW decoder: byte push, pixel pull, normal or interlaced order.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   in       | input     | in_valid_i / in_stall_o  | gifd_pkg::in_t
//   out      | output    | out_valid_o / out_stall_i | gifd_pkg::out_t
//   cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A push, or a pull once decoding has finished, goes from the queue straight
// to the result register; a pull that fetches a code and ends without a pixel
// (too few bits, end code, bad code) passes the fetch state; a pull served
// from the stack reads it first; a pull that decodes a new code fetches it,
// walks its dictionary chain onto the stack, one read per entry, and pops.
// Reset restores the control registers; the payload registers and the tables
// need no clearing pass. A stalled output holds its result while the two-entry
// queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [gifd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [gifd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  gifd_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output gifd_pkg::out_t                   out_data_o
);
  import gifd_pkg::*;

  // classified requests from the front queue to the engine
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // front: accept and classify, buffer two requests
  gifd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: unpack codes, expand strings, place pixels
  gifd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[rtl/gifd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gifd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gifd_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input gifd_pkg::out_t       out_data_o
);
  import gifd_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_OUTSIDE)
    else $error("status out of range");

  // only pixels carry index and position
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_PIXEL) |->
      (out_data_o.pixel_index == 8'd0) && (out_data_o.pixel_x == 16'd0) &&
      (out_data_o.pixel_y == 16'd0))
    else $error("non-pixel result carries data");

endmodule

bind gif_lzw_pixel_decoder gifd_checker u_gifd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

[tb/sv/tb_gif_lzw_pixel_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_pixel_decoder
// Self-checking bench: drives pushed stream bytes and pixel pulls, predicts
// results with an internal LZW decoder or takes fixed statuses from a directed table, and compares in arrival order.
// ----------------------------------------------------------------------------
module tb_gif_lzw_pixel_decoder;
  import gifd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 1700;
  localparam int HOLD_CYCLES = 400;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp_data;

  always #5 clk_i = ~clk_i;

  gif_lzw_pixel_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_data_i  (req_data),
    .out_valid_o(rsp_valid),
    .out_stall_i(rsp_stall),
    .out_data_o (rsp_data)
  );

  // --------------------------------------------------------------------------
  // Decoder predictor: its own copy of registers, tables and position state
  // --------------------------------------------------------------------------
  int unsigned reg_root = 8, reg_width = 1, reg_height = 1, reg_ilace = 0;

  logic [11:0] prefix_mem [DICT_SIZE];
  logic [7:0]  suffix_mem [DICT_SIZE];
  logic [7:0]  string_mem [DICT_SIZE];

  int unsigned     str_depth, bit_fill, block_left, code_w, free_code;
  int unsigned     last_code, lead_char, col, row, ilace_pass;
  longint unsigned bit_acc;
  bit              data_ended, have_last, decode_done;

  function automatic int unsigned root_size();
    if (reg_root < 2) return 2;
    if (reg_root > 8) return 8;
    return reg_root;
  endfunction

  function automatic void dict_reset();
    code_w    = root_size() + 1;
    free_code = (1 << root_size()) + 2;
    have_last = 1'b0;
    last_code = 0;
  endfunction

  function automatic void decoder_reset();
    str_depth   = 0;
    bit_acc     = 0;
    bit_fill    = 0;
    block_left  = 0;
    data_ended  = 1'b0;
    dict_reset();
    lead_char   = 0;
    col         = 0;
    row         = 0;
    ilace_pass  = 1;
    decode_done = 1'b0;
  endfunction

  function automatic void step_position();
    col++;
    if (col < reg_width) return;
    col = 0;
    if (reg_ilace == 0) begin
      row++;
      return;
    end
    if (ilace_pass <= 2) row += 8;
    else if (ilace_pass == 3) row += 4;
    else row += 2;
    // skip passes whose first row lies past the frame
    while (row >= reg_height && ilace_pass < 5) begin
      ilace_pass++;
      if (ilace_pass == 2) row = 4;
      else if (ilace_pass == 3) row = 2;
      else if (ilace_pass == 4) row = 1;
    end
  endfunction

  // decode the next code into the string store; ST_PIXEL means it is filled
  function automatic logic [2:0] unpack_code();
    int unsigned clr, code, c;
    while (1'b1) begin
      clr = 1 << root_size();
      if (bit_fill < code_w) begin
        if (data_ended) begin
          decode_done = 1'b1;
          return ST_DONE;
        end
        return ST_NEED;
      end
      code = int'(bit_acc & ((64'd1 << code_w) - 1));
      bit_acc >>= code_w;
      bit_fill -= code_w;
      if (code == clr) begin
        dict_reset();
        continue;
      end
      if (code == clr + 1) begin
        decode_done = 1'b1;
        return ST_DONE;
      end
      if (code >= DICT_SIZE || code > free_code || (code == free_code && !have_last)) begin
        decode_done = 1'b1;
        return ST_BADCODE;
      end
      str_depth = 0;
      c = code;
      // the KwKwK case: string of the last code plus its own first character
      if (code == free_code) begin
        string_mem[0] = lead_char[7:0];
        str_depth = 1;
        c = last_code;
      end
      while (c >= clr + 2 && str_depth < 4095) begin
        string_mem[str_depth & 4095] = suffix_mem[c & 4095];
        str_depth++;
        c = prefix_mem[c & 4095];
      end
      c &= 8'hFF;
      string_mem[str_depth & 4095] = c[7:0];
      str_depth++;
      lead_char = c;
      if (have_last && free_code < DICT_SIZE) begin
        prefix_mem[free_code & 4095] = last_code[11:0];
        suffix_mem[free_code & 4095] = c[7:0];
        free_code++;
        if (free_code >= (1 << code_w) && code_w < MAX_CODE_BITS) code_w++;
      end
      last_code = code;
      have_last = 1'b1;
      return ST_PIXEL;
    end
    return ST_PIXEL;
  endfunction

  function automatic out_t decode_request(in_t rq);
    out_t r;
    logic [2:0] st;
    r = '0;
    if (rq.opcode == OP_PUSH) begin
      if (data_ended) r.status = ST_DONE;
      else if (block_left == 0) begin
        if (rq.data_byte == 0) data_ended = 1'b1;
        else block_left = rq.data_byte;
        r.status = ST_ACCEPT;
      end else if (bit_fill + 8 > BIT_BUFFER_BITS) r.status = ST_FULL;
      else begin
        bit_acc |= longint'(rq.data_byte) << bit_fill;
        bit_fill += 8;
        block_left--;
        r.status = ST_ACCEPT;
      end
      return r;
    end
    if (str_depth == 0) begin
      if (decode_done) begin
        r.status = ST_DONE;
        return r;
      end
      st = unpack_code();
      if (st != ST_PIXEL) begin
        r.status = st;
        return r;
      end
    end
    str_depth--;
    if (row >= reg_height) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    r.status      = ST_PIXEL;
    r.pixel_index = string_mem[str_depth & 4095];
    r.pixel_x     = col[15:0];
    r.pixel_y     = row[15:0];
    step_position();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Expected results and checking at the output
  // --------------------------------------------------------------------------
  out_t pending_pixels [$];
  int   fail_count = 0;
  int   req_count = 0;

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && rsp_valid && !rsp_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp_data);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_data.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, rsp_data.status);
          fail_count++;
        end
        if (rsp_data.pixel_index !== want.pixel_index) begin
          $display("%0t: pixel_index exp %0d got %0d", $time, want.pixel_index,
                   rsp_data.pixel_index);
          fail_count++;
        end
        if (rsp_data.pixel_x !== want.pixel_x) begin
          $display("%0t: pixel_x exp %0d got %0d", $time, want.pixel_x, rsp_data.pixel_x);
          fail_count++;
        end
        if (rsp_data.pixel_y !== want.pixel_y) begin
          $display("%0t: pixel_y exp %0d got %0d", $time, want.pixel_y, rsp_data.pixel_y);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idling phases: 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  // --------------------------------------------------------------------------
  int idle_phase = 0;
  bit hold_output = 1'b0;

  // receiver: random stalls, plus one long hold to fill the block
  initial begin
    int held;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        rsp_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (idle_phase == 2) rsp_stall <= ($urandom_range(0, 99) < 74);
      else if (idle_phase == 3) rsp_stall <= ($urandom_range(0, 99) < 11);
      else rsp_stall <= 1'b0;
    end
  end

  function automatic bit sender_idles();
    if (idle_phase == 1) return $urandom_range(0, 99) < 74;
    if (idle_phase == 3) return $urandom_range(0, 99) < 11;
    return 1'b0;
  endfunction

  // offer one request, hold it until taken, then log its expected result
  task automatic send_request(input in_t rq, input bit fixed, input logic [2:0] fixed_st,
                              output out_t got);
    out_t fixed_rsp;
    @(negedge clk_i);
    while (sender_idles()) begin
      req_valid <= 1'b0;
      @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    do @(posedge clk_i); while (req_stall);
    got = decode_request(rq);
    if (fixed) begin
      fixed_rsp = '0;
      fixed_rsp.status = fixed_st;
      pending_pixels.push_back(fixed_rsp);
    end else pending_pixels.push_back(got);
    req_count++;
  endtask

  // drop valid, wait until every result is back, then let the pipe settle
  task automatic drain_block();
    @(negedge clk_i);
    req_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // register write; the block and the predictor restart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROOT_BITS:  reg_root  = val[3:0];
      CFG_WIDTH:      reg_width = val;
      CFG_HEIGHT:     reg_height = val;
      CFG_INTERLACED: reg_ilace = val[0];
      default: ;
    endcase
    decoder_reset();
  endtask

  // --------------------------------------------------------------------------
  // Stream builder: mostly well-formed code streams, some raw noise
  // --------------------------------------------------------------------------
  logic [7:0] stream_bytes [$];

  task automatic build_codes(input int n_codes, input bit close_stream);
    logic [7:0]  packed_bytes [$];
    longint unsigned acc;
    int unsigned nbits, r, clr, nf, w, code, i, len, pos;
    bit prev;
    acc = 0;
    nbits = 0;
    r = root_size();
    clr = 1 << r;
    nf = clr + 2;
    w = r + 1;
    prev = 1'b0;
    for (i = 0; i <= n_codes; i++) begin
      if (i == 0 || $urandom_range(0, 39) == 0) code = clr;
      else if (i == n_codes) code = clr + 1;
      else if (prev && nf > clr + 2 && $urandom_range(0, 99) < 60)
        code = $urandom_range(clr + 2, nf - 1);
      else if (prev && nf < DICT_SIZE && $urandom_range(0, 9) == 0) code = nf;
      else code = $urandom_range(0, clr - 1);
      // emit at the width in force, then track the decoder's growth
      acc |= longint'(code) << nbits;
      nbits += w;
      while (nbits >= 8) begin
        packed_bytes.push_back(acc[7:0]);
        acc >>= 8;
        nbits -= 8;
      end
      if (code == clr) begin
        nf = clr + 2;
        w = r + 1;
        prev = 1'b0;
      end else if (code != clr + 1) begin
        if (prev && nf < DICT_SIZE) begin
          nf++;
          if (nf >= (1 << w) && w < MAX_CODE_BITS) w++;
        end
        prev = 1'b1;
      end
    end
    if (nbits > 0) packed_bytes.push_back(acc[7:0]);
    // split into sub-blocks, each led by its length byte
    stream_bytes.delete();
    pos = 0;
    while (pos < packed_bytes.size()) begin
      len = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 6);
      if (len > packed_bytes.size() - pos) len = packed_bytes.size() - pos;
      stream_bytes.push_back(len[7:0]);
      repeat (len) begin
        stream_bytes.push_back(packed_bytes[pos]);
        pos++;
      end
    end
    if (close_stream) stream_bytes.push_back(8'h00);
  endtask

  task automatic build_noise(input int n);
    stream_bytes.delete();
    repeat (n) stream_bytes.push_back($urandom_range(0, 255));
  endtask

  function automatic logic [15:0] pick_size(input int top);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'hFFFF;
    if (k == 2) return $urandom_range(0, 65535);
    return $urandom_range(1, top);
  endfunction

  // feed one stream with pulls mixed in, pulling on until the decoder ends or starves
  task automatic play_stream();
    in_t rq;
    out_t got;
    int unsigned pos, pulls, starved;
    bit ended, must_pull;
    pos = 0;
    pulls = 0;
    starved = 0;
    ended = 1'b0;
    must_pull = 1'b0;
    while (pulls < 600) begin
      if (pos < stream_bytes.size() && !must_pull && (ended || $urandom_range(0, 1))) begin
        rq.opcode = OP_PUSH;
        rq.data_byte = stream_bytes[pos];
        send_request(rq, 1'b0, ST_PIXEL, got);
        // a refused byte goes again after a pull has made room
        if (got.status == ST_FULL && !ended) must_pull = 1'b1;
        else pos++;
      end else begin
        if (pos >= stream_bytes.size() && (ended || starved >= 3)) break;
        rq.opcode = OP_PULL;
        rq.data_byte = $urandom_range(0, 255);
        send_request(rq, 1'b0, ST_PIXEL, got);
        pulls++;
        must_pull = 1'b0;
        if (got.status == ST_DONE || got.status == ST_BADCODE) ended = 1'b1;
        if (got.status == ST_NEED && pos >= stream_bytes.size()) starved++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table: rows either write a register or offer one request
  // --------------------------------------------------------------------------
  typedef struct {
    bit          is_reg;
    logic [1:0]  idx;
    logic [15:0] val;
    logic        op;
    logic [7:0]  dat;
    bit          fixed;
    logic [2:0]  st;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_req(logic op, logic [7:0] dat, bit fixed, logic [2:0] st);
    dir_rows.push_back('{1'b0, CFG_ROOT_BITS, 16'd0, op, dat, fixed, st});
  endfunction

  function automatic void add_reg(logic [1:0] idx, logic [15:0] val);
    dir_rows.push_back('{1'b1, idx, val, OP_PUSH, 8'd0, 1'b0, ST_PIXEL});
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_t  rq;
    out_t got;
    int   frame;
    for (int i = 0; i < DICT_SIZE; i++) begin
      prefix_mem[i] = '0;
      suffix_mem[i] = '0;
      string_mem[i] = '0;
    end
    decoder_reset();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults, root 8: clear, 0xFF, 0x00, a KwKwK code, end
    add_req(OP_PULL, 8'h00, 1'b1, ST_NEED);
    add_req(OP_PUSH, 8'h06, 1'b1, ST_ACCEPT);
    add_req(OP_PUSH, 8'h00, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'hFF, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h01, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h18, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h18, 1'b1, ST_FULL);    // buffer holds 32 bits
    add_req(OP_PULL, 8'hFF, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h18, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h10, 1'b0, ST_PIXEL);
    add_req(OP_PUSH, 8'h00, 1'b1, ST_ACCEPT);  // end of data
    add_req(OP_PUSH, 8'hA5, 1'b1, ST_DONE);    // push after end of data
    repeat (6) add_req(OP_PULL, 8'h00, 1'b0, ST_PIXEL);
    // root 2: clear then a code beyond the free slot
    add_reg(CFG_ROOT_BITS, 16'd2);
    add_req(OP_PUSH, 8'h01, 1'b1, ST_ACCEPT);
    add_req(OP_PUSH, 8'h3C, 1'b1, ST_ACCEPT);
    add_req(OP_PULL, 8'h00, 1'b1, ST_BADCODE);
    add_req(OP_PULL, 8'h00, 1'b1, ST_DONE);
    add_reg(CFG_WIDTH, 16'hFFFF);
    add_reg(CFG_HEIGHT, 16'hFFFF);
    add_reg(CFG_INTERLACED, 16'd1);
    add_reg(CFG_ROOT_BITS, 16'd15);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        drain_block();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        rq.opcode = dir_rows[i].op;
        rq.data_byte = dir_rows[i].dat;
        send_request(rq, dir_rows[i].fixed, dir_rows[i].st, got);
      end
    end

    // random frames, cycling the idling phases frame by frame
    frame = 0;
    while (req_count < ITEM_GOAL) begin
      drain_block();
      idle_phase = frame % 4;
      write_reg(CFG_ROOT_BITS, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(2, 8));
      write_reg(CFG_WIDTH, pick_size(6));
      write_reg(CFG_HEIGHT, pick_size(12));
      write_reg(CFG_INTERLACED, $urandom_range(0, 1));
      if (frame == 2) hold_output = 1'b1;
      if ($urandom_range(0, 9) == 0) build_noise($urandom_range(4, 40));
      else build_codes($urandom_range(4, 60), $urandom_range(0, 9) != 0);
      play_stream();
      frame++;
    end

    drain_block();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/gifd_pkg.sv
rtl/gifd_front.sv
rtl/gifd_engine.sv
rtl/gif_lzw_pixel_decoder.sv
rtl/gifd_checker.sv
tb/sv/tb_gif_lzw_pixel_decoder.sv
